// ----- rtl/ptw_pkg.sv -----
// shared types and constants for the four-level page table walker
`default_nettype none

package ptw_pkg;

  localparam int ADDR_W  = 48;
  localparam int DATA_W  = 64;
  localparam int FRAME_W = 36;
  localparam int INDEX_W = 9;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_READ_DATA = 1'b1;

  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_DONE     = 1'b1;

  localparam logic [1:0] LEVEL_0 = 2'd0;
  localparam logic [1:0] LEVEL_1 = 2'd1;
  localparam logic [1:0] LEVEL_2 = 2'd2;
  localparam logic [1:0] LEVEL_3 = 2'd3;

  localparam int BIT_VALID = 0;
  localparam int BIT_TABLE = 1;

  typedef struct packed {
    logic               is_read;
    logic [ADDR_W-1:0]  va;
    logic [FRAME_W-1:0] frame;
    logic               is_valid;
    logic               is_table;
  } ptw_item_t;

endpackage

`default_nettype wire

// ----- rtl/ptw_front.sv -----
// front stage: takes input transactions and decodes them into queue entries
`default_nettype none

module ptw_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic                   command,
  input  wire logic [47:0]            virtual_address,
  input  wire logic [63:0]            read_data,
  output logic                        push,
  output ptw_pkg::ptw_item_t          push_item,
  input  wire logic                   queue_full
);
  import ptw_pkg::*;

  logic      front_valid;
  ptw_item_t front_item;
  ptw_item_t decoded;
  logic      accept;

  always_comb begin
    decoded.is_read  = (command == CMD_READ_DATA);
    decoded.va       = virtual_address;
    decoded.frame    = read_data[ADDR_W-1:ADDR_W-FRAME_W];
    decoded.is_valid = read_data[BIT_VALID];
    decoded.is_table = read_data[BIT_TABLE];
  end

  assign push       = front_valid && !queue_full;
  assign item_stall = front_valid && queue_full;
  assign accept     = item_valid && !item_stall;
  assign push_item  = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
    if (accept) begin
      front_item <= decoded;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ptw_queue.sv -----
// small fifo of decoded transactions between front and back
`default_nettype none

module ptw_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ptw_pkg::ptw_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output ptw_pkg::ptw_item_t      head_item
);
  import ptw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ptw_item_t           slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ptw_back.sv -----
// back stage: walk state, table base register and result register
`default_nettype none

module ptw_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               ttbr_we,
  input  wire logic [47:0]        ttbr_data,
  input  wire logic               head_valid,
  input  wire ptw_pkg::ptw_item_t head_item,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    result_kind,
  output logic [47:0]             read_address,
  output logic [47:0]             physical_address,
  output logic                    fault
);
  import ptw_pkg::*;

  logic [ADDR_W-1:0]  ttbr;
  logic               walk_active;
  logic [1:0]         walk_level;
  logic [ADDR_W-1:0]  saved_va;

  logic               walk_active_next;
  logic [1:0]         walk_level_next;
  logic [ADDR_W-1:0]  saved_va_next;
  logic               kind_next;
  logic [ADDR_W-1:0]  ra_next;
  logic [ADDR_W-1:0]  pa_next;
  logic               fault_next;
  logic [1:0]         idx_level;
  logic [ADDR_W-1:0]  idx_va;
  logic [INDEX_W-1:0] level_idx;
  logic [FRAME_W-1:0] base_frame;

  assign pop = head_valid && (!result_valid || !result_stall);

  // level, address and frame that the next read request uses
  always_comb begin
    if (!head_item.is_read) begin
      idx_level  = LEVEL_0;
      idx_va     = head_item.va;
      base_frame = ttbr[ADDR_W-1:ADDR_W-FRAME_W];
    end else begin
      idx_level  = walk_level + 2'd1;
      idx_va     = saved_va;
      base_frame = head_item.frame;
    end
  end

  // 9-bit table index of the chosen level
  always_comb begin
    unique case (idx_level)
      LEVEL_0: level_idx = idx_va[47:39];
      LEVEL_1: level_idx = idx_va[38:30];
      LEVEL_2: level_idx = idx_va[29:21];
      LEVEL_3: level_idx = idx_va[20:12];
      default: level_idx = idx_va[47:39];
    endcase
  end

  always_comb begin
    walk_active_next = walk_active;
    walk_level_next  = walk_level;
    saved_va_next    = saved_va;
    kind_next        = KIND_DONE;
    ra_next          = '0;
    pa_next          = '0;
    fault_next       = 1'b1;
    if (!head_item.is_read) begin
      saved_va_next    = head_item.va;
      walk_active_next = 1'b1;
      walk_level_next  = LEVEL_0;
      kind_next        = KIND_READ_REQ;
      fault_next       = 1'b0;
      ra_next          = {base_frame, level_idx, 3'b000};
    end else if (walk_active) begin
      walk_active_next = 1'b0;
      walk_level_next  = LEVEL_0;
      if (head_item.is_valid) begin
        unique case (walk_level)
          LEVEL_0: begin
            if (head_item.is_table) begin
              walk_active_next = 1'b1;
              walk_level_next  = LEVEL_1;
              kind_next        = KIND_READ_REQ;
              fault_next       = 1'b0;
              ra_next          = {base_frame, level_idx, 3'b000};
            end
          end
          LEVEL_1: begin
            fault_next = 1'b0;
            if (head_item.is_table) begin
              walk_active_next = 1'b1;
              walk_level_next  = LEVEL_2;
              kind_next        = KIND_READ_REQ;
              ra_next          = {base_frame, level_idx, 3'b000};
            end else begin
              pa_next = {head_item.frame[FRAME_W-1:18], saved_va[29:0]};
            end
          end
          LEVEL_2: begin
            fault_next = 1'b0;
            if (head_item.is_table) begin
              walk_active_next = 1'b1;
              walk_level_next  = LEVEL_3;
              kind_next        = KIND_READ_REQ;
              ra_next          = {base_frame, level_idx, 3'b000};
            end else begin
              pa_next = {head_item.frame[FRAME_W-1:9], saved_va[20:0]};
            end
          end
          LEVEL_3: begin
            if (head_item.is_table) begin
              fault_next = 1'b0;
              pa_next    = {head_item.frame, saved_va[11:0]};
            end
          end
          default: begin
            fault_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttbr         <= '0;
      walk_active  <= 1'b0;
      walk_level   <= LEVEL_0;
      saved_va     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ttbr_we) begin
        ttbr <= ttbr_data;
      end
      if (pop) begin
        walk_active  <= walk_active_next;
        walk_level   <= walk_level_next;
        saved_va     <= saved_va_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (pop) begin
      result_kind      <= kind_next;
      read_address     <= ra_next;
      physical_address <= pa_next;
      fault            <= fault_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/four_level_page_table_walker.sv -----
// top level of the four-level page table walker
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     command, virtual_address, read_data
//   result    out        result_valid / result_stall result_kind, read_address,
//                                                    physical_address, fault
//   config    in         ttbr_we                     ttbr_data
//
// one transaction per cycle sustained while item_stall is low; after the item is taken
// the result passes the front register, a queue slot and the result register
// synchronous reset clears the walk state, the table base and all valid flags
// front and back stall on their own; the queue of QUEUE_DEPTH entries absorbs
// a result stall while the front keeps taking items
`default_nettype none

module four_level_page_table_walker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ttbr_we,
  input  wire logic [47:0] ttbr_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        command,
  input  wire logic [47:0] virtual_address,
  input  wire logic [63:0] read_data,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             result_kind,
  output logic [47:0]      read_address,
  output logic [47:0]      physical_address,
  output logic             fault
);
  import ptw_pkg::*;

  logic      push;
  ptw_item_t push_item;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  ptw_item_t head_item;

  ptw_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .virtual_address (virtual_address),
    .read_data       (read_data),
    .push            (push),
    .push_item       (push_item),
    .queue_full      (queue_full)
  );

  ptw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ptw_back u_back (
    .clk              (clk),
    .rst              (rst),
    .ttbr_we          (ttbr_we),
    .ttbr_data        (ttbr_data),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_kind      (result_kind),
    .read_address     (read_address),
    .physical_address (physical_address),
    .fault            (fault)
  );

endmodule

`default_nettype wire
